[rtl/thef_pkg.sv]
// Shared constants and types for the tiled Haar edge feature unit.
`default_nettype none

package thef_pkg;

  localparam int unsigned DefMaxImageWidth  = 512;
  localparam int unsigned DefMaxImageHeight = 512;
  localparam int unsigned DefMaxTileColumns = 256;
  localparam int unsigned DefFeatureBits    = 16;

  localparam int unsigned PixelW   = 8;
  localparam int unsigned WinMax   = 64;
  localparam int unsigned WinW     = 7;
  localparam int unsigned CwW      = 6;
  localparam int unsigned ImgRegW  = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Reset values of the configuration registers.
  localparam int unsigned RstImageWidth   = 64;
  localparam int unsigned RstImageHeight  = 64;
  localparam int unsigned RstWindowWidth  = 8;
  localparam int unsigned RstWindowHeight = 8;

  // One tile row segment: at most 64 pixels of +-255.
  localparam int unsigned SegW = 16;
  // Whole tile: at most 64*64 pixels of +-255.
  localparam int unsigned SumW = 22;
  // Pixel count of a tile (up to 4096) and count * 255.
  localparam int unsigned NW   = 13;
  localparam int unsigned DW   = 20;

  localparam int unsigned FifoDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth   = 2'd0,
    CfgImageHeight  = 2'd1,
    CfgWindowWidth  = 2'd2,
    CfgWindowHeight = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    BkIdle,
    BkDiv
  } back_state_e;

  typedef struct packed {
    logic [WinW-1:0] ww;
    logic [WinW-1:0] wh;
  } win_cfg_t;

endpackage

`default_nettype wire

[rtl/thef_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module thef_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/thef_fifo.sv]
// Small tile queue between the pixel front end and the divider back end.
`default_nettype none

module thef_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [Width-1:0] data_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("tile queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("tile queue underflow");

endmodule

`default_nettype wire

[rtl/thef_front.sv]
// Pixel front end: raster counters, tile membership and per-tile difference sums.
`default_nettype none

module thef_front #(
  parameter int unsigned MAX_IMAGE_WIDTH  = thef_pkg::DefMaxImageWidth,
  parameter int unsigned MAX_IMAGE_HEIGHT = thef_pkg::DefMaxImageHeight,
  parameter int unsigned MAX_TILE_COLUMNS = thef_pkg::DefMaxTileColumns,
  localparam int unsigned IWW   = $clog2(MAX_IMAGE_WIDTH + 1),
  localparam int unsigned IHW   = $clog2(MAX_IMAGE_HEIGHT + 1),
  localparam int unsigned PCW   = $clog2(MAX_IMAGE_WIDTH),
  localparam int unsigned RowW  = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1,
  localparam int unsigned TCW   = $clog2(MAX_IMAGE_WIDTH / 2),
  localparam int unsigned ColW  = $clog2(MAX_TILE_COLUMNS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            restart_i,
  input  wire thef_pkg::win_cfg_t              win_i,
  input  wire logic [IWW-1:0]                  img_w_i,
  input  wire logic [IHW-1:0]                  img_h_i,
  input  wire logic                            in_valid_i,
  input  wire logic [thef_pkg::PixelW-1:0]     pixel_value_i,
  output logic                                 in_stall_o,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output logic      [thef_pkg::SumW-1:0]       tile_sum_o,
  output logic      [RowW-1:0]                 tile_row_o,
  output logic      [ColW-1:0]                 tile_col_o,
  output logic                                 tile_last_o
);

  localparam int unsigned WinW   = thef_pkg::WinW;
  localparam int unsigned CwW    = thef_pkg::CwW;
  localparam int unsigned PixelW = thef_pkg::PixelW;
  localparam int unsigned SegW   = thef_pkg::SegW;
  localparam int unsigned SumW   = thef_pkg::SumW;
  localparam int unsigned CmpCW  = ((IWW > WinW + 1) ? IWW : WinW + 1) + 1;
  localparam int unsigned CmpRW  = ((IHW > WinW + 1) ? IHW : WinW + 1) + 1;
  localparam int unsigned TcExtW = TCW + ColW;

  logic [PCW-1:0]  pc_q, pc_d;
  logic [RowW-1:0] pr_q, pr_d;
  logic [CwW-1:0]  cw_q, cw_d;
  logic [CwW-1:0]  rw_q, rw_d;
  logic [TCW-1:0]  tc_q, tc_d;
  logic [RowW-1:0] tr_q, tr_d;
  logic [PCW-1:0]  col_base_q, col_base_d;
  logic [RowW-1:0] row_base_q, row_base_d;
  logic [SegW-1:0] seg_q;

  logic [WinW-1:0]   ww, wh, half_ww;
  logic              accept;
  logic              col_fits, row_fits, tc_ok, in_tile;
  logic              col_last, row_last;
  logic              seg_end, rw_end;
  logic [TcExtW-1:0] tc_ext;
  logic [ColW-1:0]   tile_addr;
  logic [PixelW:0]   contrib;
  logic [SegW-1:0]   seg_base, seg_sum;
  logic [SumW-1:0]   tile_base, tile_sum;
  logic [SumW-1:0]   ram_rdata;
  logic              ram_we;

  logic [CmpCW-1:0]  pc_inc, col_step;
  logic [CmpRW-1:0]  pr_inc;
  logic [WinW-1:0]   cw_inc, rw_inc;
  logic [CmpRW-1:0]  row_step;

  assign ww      = win_i.ww;
  assign wh      = win_i.wh;
  assign half_ww = ww >> 1;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign col_fits = (CmpCW'(col_base_q) + CmpCW'(ww)) <= CmpCW'(img_w_i);
  assign row_fits = (CmpRW'(row_base_q) + CmpRW'(wh)) <= CmpRW'(img_h_i);
  assign col_last = (CmpCW'(col_base_q) + CmpCW'({ww, 1'b0})) > CmpCW'(img_w_i);
  assign row_last = (CmpRW'(row_base_q) + CmpRW'({wh, 1'b0})) > CmpRW'(img_h_i);

  assign tc_ext    = TcExtW'(tc_q);
  assign tc_ok     = tc_ext < TcExtW'(MAX_TILE_COLUMNS);
  assign tile_addr = tc_ext[ColW-1:0];
  assign in_tile   = col_fits && row_fits && tc_ok;

  assign seg_end = (WinW'(cw_q) == ww - 1'b1);
  assign rw_end  = (WinW'(rw_q) == wh - 1'b1);

  // Left half subtracts, right half adds.
  always_comb begin
    if (WinW'(cw_q) < half_ww) begin
      contrib = (PixelW + 1)'(0) - {1'b0, pixel_value_i};
    end else begin
      contrib = {1'b0, pixel_value_i};
    end
    seg_base  = (cw_q == '0) ? '0 : seg_q;
    seg_sum   = seg_base + {{(SegW - PixelW - 1){contrib[PixelW]}}, contrib};
    tile_base = (rw_q == '0) ? '0 : ram_rdata;
    tile_sum  = tile_base + {{(SumW - SegW){seg_sum[SegW-1]}}, seg_sum};
  end

  // Partial sums of earlier rows of each tile column, folded in once per segment.
  assign ram_we = accept && in_tile && seg_end;

  thef_ram #(
    .Width (SumW),
    .Depth (MAX_TILE_COLUMNS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tile_addr),
    .wdata_i (tile_sum),
    .raddr_i (tile_addr),
    .rdata_o (ram_rdata)
  );

  assign q_push_o    = ram_we && rw_end;
  assign tile_sum_o  = tile_sum;
  assign tile_row_o  = tr_q;
  assign tile_col_o  = tile_addr;
  assign tile_last_o = row_last &&
                       (col_last || (tc_ext == TcExtW'(MAX_TILE_COLUMNS - 1)));

  always_comb begin
    pc_d       = pc_q;
    pr_d       = pr_q;
    cw_d       = cw_q;
    rw_d       = rw_q;
    tc_d       = tc_q;
    tr_d       = tr_q;
    col_base_d = col_base_q;
    row_base_d = row_base_q;
    pc_inc     = CmpCW'(pc_q) + 1'b1;
    pr_inc     = CmpRW'(pr_q) + 1'b1;
    cw_inc     = WinW'(cw_q) + 1'b1;
    rw_inc     = WinW'(rw_q) + 1'b1;
    col_step   = CmpCW'(col_base_q) + CmpCW'(ww);
    row_step   = CmpRW'(row_base_q) + CmpRW'(wh);
    if (restart_i) begin
      pc_d       = '0;
      pr_d       = '0;
      cw_d       = '0;
      rw_d       = '0;
      tc_d       = '0;
      tr_d       = '0;
      col_base_d = '0;
      row_base_d = '0;
    end else if (accept) begin
      if (cw_inc >= ww) begin
        cw_d       = '0;
        tc_d       = tc_q + 1'b1;
        col_base_d = col_step[PCW-1:0];
      end else begin
        cw_d = cw_inc[CwW-1:0];
      end
      if (pc_inc >= CmpCW'(img_w_i)) begin
        pc_d       = '0;
        cw_d       = '0;
        tc_d       = '0;
        col_base_d = '0;
        if (rw_inc >= wh) begin
          rw_d       = '0;
          tr_d       = tr_q + 1'b1;
          row_base_d = row_step[RowW-1:0];
        end else begin
          rw_d = rw_inc[CwW-1:0];
        end
        if (pr_inc >= CmpRW'(img_h_i)) begin
          pr_d       = '0;
          rw_d       = '0;
          tr_d       = '0;
          row_base_d = '0;
        end else begin
          pr_d = pr_inc[RowW-1:0];
        end
      end else begin
        pc_d = pc_inc[PCW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      pr_q       <= '0;
      cw_q       <= '0;
      rw_q       <= '0;
      tc_q       <= '0;
      tr_q       <= '0;
      col_base_q <= '0;
      row_base_q <= '0;
    end else begin
      pc_q       <= pc_d;
      pr_q       <= pr_d;
      cw_q       <= cw_d;
      rw_q       <= rw_d;
      tc_q       <= tc_d;
      tr_q       <= tr_d;
      col_base_q <= col_base_d;
      row_base_q <= row_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_tile) begin
      seg_q <= seg_sum;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) WinW'(cw_q) < ww)
    else $error("column within tile out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) WinW'(rw_q) < wh)
    else $error("row within tile out of range");

endmodule

`default_nettype wire

[rtl/thef_back.sv]
// Divider back end: normalizes a finished tile sum to a clamped Q0.N feature.
`default_nettype none

module thef_back #(
  parameter int unsigned FEATURE_BITS = thef_pkg::DefFeatureBits,
  parameter int unsigned RowW         = 9,
  parameter int unsigned ColW         = 8,
  localparam int unsigned CntW        = $clog2(FEATURE_BITS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire thef_pkg::win_cfg_t          win_i,
  input  wire logic                        q_empty_i,
  output logic                             q_pop_o,
  input  wire logic [thef_pkg::SumW-1:0]   q_sum_i,
  input  wire logic [RowW-1:0]             q_row_i,
  input  wire logic [ColW-1:0]             q_col_i,
  input  wire logic                        q_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [FEATURE_BITS-1:0]     feature_o,
  output logic      [RowW-1:0]             tile_row_o,
  output logic      [ColW-1:0]             tile_col_o,
  output logic                             last_of_image_o
);

  localparam int unsigned WinW = thef_pkg::WinW;
  localparam int unsigned SumW = thef_pkg::SumW;
  localparam int unsigned NW   = thef_pkg::NW;
  localparam int unsigned DW   = thef_pkg::DW;

  thef_pkg::back_state_e st_q, st_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  logic [NW-1:0]           n_q;
  logic [DW-1:0]           d_q, h_q;
  logic [DW-1:0]           rem_q, rem_d;
  logic [FEATURE_BITS-1:0] quo_q, quo_d;
  logic [RowW-1:0]         row_q, row_d;
  logic [ColW-1:0]         col_q, col_d;
  logic                    last_q, last_d;
  logic [FEATURE_BITS-1:0] feat_q, feat_d;
  logic [RowW-1:0]         orow_q, orow_d;
  logic [ColW-1:0]         ocol_q, ocol_d;
  logic                    olast_q, olast_d;

  logic [2*WinW-1:0]       n_prod;
  logic [NW+7:0]           d_full;
  logic [DW-1:0]           h_full;
  logic [NW-2:0]           n_half;
  logic [SumW:0]           num;
  logic                    num_pos, num_ge_d;
  logic [DW:0]             rem_x2;
  logic                    bit_ge;
  logic [DW:0]             rem_sub;
  logic [DW-1:0]           rem_nx;
  logic [FEATURE_BITS-1:0] quo_nx;
  logic                    slot_free;

  function automatic logic [2*WinW-1:0] ww_h_mul(input thef_pkg::win_cfg_t w);
    ww_h_mul = w.ww * w.wh;
  endfunction

  // Per-window constants are registered: n_q from the window size, then d_q and h_q from n_q.
  assign n_prod = ww_h_mul(win_i);
  assign d_full = {n_q, 8'b0} - (NW + 8)'(n_q);
  assign n_half = n_q[NW-1:1];
  assign h_full = {n_half, 8'b0} - DW'(n_half);

  always_ff @(posedge clk_i) begin
    n_q <= n_prod[NW-1:0];
    d_q <= d_full[DW-1:0];
    h_q <= h_full;
  end

  assign num      = {q_sum_i[SumW-1], q_sum_i} + {{(SumW + 1 - DW){1'b0}}, h_q};
  assign num_pos  = !num[SumW] && (num != '0);
  assign num_ge_d = num_pos && (num[SumW-1:0] >= SumW'(d_q));

  // One restoring step per cycle (last waits for output room); remainder always < divisor.
  assign rem_x2  = {rem_q, 1'b0};
  assign bit_ge  = rem_x2 >= {1'b0, d_q};
  assign rem_sub = rem_x2 - {1'b0, d_q};
  assign rem_nx  = bit_ge ? rem_sub[DW-1:0] : rem_x2[DW-1:0];
  assign quo_nx  = {quo_q[FEATURE_BITS-2:0], bit_ge};

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    row_d       = row_q;
    col_d       = col_q;
    last_d      = last_q;
    feat_d      = feat_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    olast_d     = olast_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      thef_pkg::BkIdle: begin
        if (!q_empty_i && slot_free) begin
          q_pop_o = 1'b1;
          if (num_pos && !num_ge_d) begin
            st_d   = thef_pkg::BkDiv;
            cnt_d  = CntW'(FEATURE_BITS);
            rem_d  = num[DW-1:0];
            quo_d  = '0;
            row_d  = q_row_i;
            col_d  = q_col_i;
            last_d = q_last_i;
          end else begin
            // Nonpositive numerator floors to zero, one or more saturates.
            out_valid_d = 1'b1;
            feat_d      = num_ge_d ? '1 : '0;
            orow_d      = q_row_i;
            ocol_d      = q_col_i;
            olast_d     = q_last_i;
          end
        end
      end
      thef_pkg::BkDiv: begin
        if (cnt_q != CntW'(1) || slot_free) begin
          rem_d = rem_nx;
          quo_d = quo_nx;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            st_d        = thef_pkg::BkIdle;
            out_valid_d = 1'b1;
            feat_d      = quo_nx;
            orow_d      = row_q;
            ocol_d      = col_q;
            olast_d     = last_q;
          end
        end
      end
      default: begin
        st_d = thef_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= thef_pkg::BkIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    row_q   <= row_d;
    col_q   <= col_d;
    last_q  <= last_d;
    feat_q  <= feat_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign feature_o       = feat_q;
  assign tile_row_o      = orow_q;
  assign tile_col_o      = ocol_q;
  assign last_of_image_o = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q == thef_pkg::BkDiv) |-> (cnt_q != '0))
    else $error("divider running with no steps left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q == thef_pkg::BkDiv) |-> (rem_q < d_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[rtl/tiled_haar_edge_feature_unit.sv]
// Top level: tiled two-rectangle Haar edge feature over a raster pixel stream.
//
// Pixels enter in raster order on the in_* channel (accepted when in_valid_i is high and
// in_stall_o is low). Each full window tile yields one result on the out_* channel: the
// right-minus-left contrast as unsigned Q0.FEATURE_BITS, the tile's row and column index
// and a flag on the image's last tile. Pixels outside full tiles produce nothing.
// The cfg channel writes image width/height and window width/height by index; cfg_ready_o
// is always high and any write restarts the image at its top-left pixel.
// Throughput: one pixel per cycle while the four-entry tile queue has room. The divider
// picks up a tile, then runs FEATURE_BITS steps of restoring division. Tiles
// on the bottom line of a tile row finish one window width apart, so windows narrower
// than FEATURE_BITS+1 pixels can outrun the divider until the queue fills.
// A result is registered on the last division step, or straight at pickup for numerators
// that floor to zero or saturate.
// When the receiver stalls, the result holds in the output register, the queue fills and
// then in_stall_o rises. Reset loads 64x64 image and 8x8 window and clears all counters,
// the queue and the output valid; no clearing pass is needed.
`default_nettype none

module tiled_haar_edge_feature_unit #(
  parameter int unsigned MAX_IMAGE_WIDTH  = thef_pkg::DefMaxImageWidth,
  parameter int unsigned MAX_IMAGE_HEIGHT = thef_pkg::DefMaxImageHeight,
  parameter int unsigned MAX_TILE_COLUMNS = thef_pkg::DefMaxTileColumns,
  parameter int unsigned FEATURE_BITS     = thef_pkg::DefFeatureBits,
  localparam int unsigned RowW = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1,
  localparam int unsigned ColW = $clog2(MAX_TILE_COLUMNS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [thef_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [thef_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [thef_pkg::PixelW-1:0]     pixel_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [FEATURE_BITS-1:0]         feature_o,
  output logic      [RowW-1:0]                 tile_row_o,
  output logic      [ColW-1:0]                 tile_col_o,
  output logic                                 last_of_image_o
);

  localparam int unsigned WinW    = thef_pkg::WinW;
  localparam int unsigned ImgRegW = thef_pkg::ImgRegW;
  localparam int unsigned SumW    = thef_pkg::SumW;
  localparam int unsigned IWW     = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int unsigned IHW     = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int unsigned EntryW  = SumW + RowW + ColW + 1;

  logic [ImgRegW-1:0] img_w_q, img_w_d;
  logic [ImgRegW-1:0] img_h_q, img_h_d;
  logic [WinW-1:0]    win_w_q, win_w_d;
  logic [WinW-1:0]    win_h_q, win_h_d;
  logic               cfg_we, restart;

  logic [ImgRegW+IWW-1:0] img_w_wide;
  logic [ImgRegW+IHW-1:0] img_h_wide;
  logic [IWW-1:0]         img_w_sat;
  logic [IHW-1:0]         img_h_sat;
  thef_pkg::win_cfg_t     win_sat;

  logic              q_push, q_full, q_pop, q_empty;
  logic [EntryW-1:0] q_wdata, q_rdata;
  logic [SumW-1:0]   f_sum;
  logic [RowW-1:0]   f_row;
  logic [ColW-1:0]   f_col;
  logic              f_last;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    img_w_d = img_w_q;
    img_h_d = img_h_q;
    win_w_d = win_w_q;
    win_h_d = win_h_q;
    restart = 1'b0;
    if (cfg_we) begin
      case (thef_pkg::cfg_reg_e'(cfg_index_i))
        thef_pkg::CfgImageWidth: begin
          img_w_d = cfg_data_i;
          restart = 1'b1;
        end
        thef_pkg::CfgImageHeight: begin
          img_h_d = cfg_data_i;
          restart = 1'b1;
        end
        thef_pkg::CfgWindowWidth: begin
          win_w_d = cfg_data_i[WinW-1:0];
          restart = 1'b1;
        end
        thef_pkg::CfgWindowHeight: begin
          win_h_d = cfg_data_i[WinW-1:0];
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ImgRegW'(thef_pkg::RstImageWidth);
      img_h_q <= ImgRegW'(thef_pkg::RstImageHeight);
      win_w_q <= WinW'(thef_pkg::RstWindowWidth);
      win_h_q <= WinW'(thef_pkg::RstWindowHeight);
    end else begin
      img_w_q <= img_w_d;
      img_h_q <= img_h_d;
      win_w_q <= win_w_d;
      win_h_q <= win_h_d;
    end
  end

  // Clamp the registers into their usable ranges.
  always_comb begin
    img_w_wide = (ImgRegW + IWW)'(img_w_q);
    img_h_wide = (ImgRegW + IHW)'(img_h_q);
    if (img_w_wide < (ImgRegW + IWW)'(2)) begin
      img_w_sat = IWW'(2);
    end else if (img_w_wide > (ImgRegW + IWW)'(MAX_IMAGE_WIDTH)) begin
      img_w_sat = IWW'(MAX_IMAGE_WIDTH);
    end else begin
      img_w_sat = img_w_wide[IWW-1:0];
    end
    if (img_h_wide < (ImgRegW + IHW)'(1)) begin
      img_h_sat = IHW'(1);
    end else if (img_h_wide > (ImgRegW + IHW)'(MAX_IMAGE_HEIGHT)) begin
      img_h_sat = IHW'(MAX_IMAGE_HEIGHT);
    end else begin
      img_h_sat = img_h_wide[IHW-1:0];
    end
    if (win_w_q < WinW'(2)) begin
      win_sat.ww = WinW'(2);
    end else if (win_w_q > WinW'(thef_pkg::WinMax)) begin
      win_sat.ww = WinW'(thef_pkg::WinMax);
    end else begin
      win_sat.ww = win_w_q;
    end
    if (win_h_q < WinW'(1)) begin
      win_sat.wh = WinW'(1);
    end else if (win_h_q > WinW'(thef_pkg::WinMax)) begin
      win_sat.wh = WinW'(thef_pkg::WinMax);
    end else begin
      win_sat.wh = win_h_q;
    end
  end

  thef_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
    .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .win_i         (win_sat),
    .img_w_i       (img_w_sat),
    .img_h_i       (img_h_sat),
    .in_valid_i    (in_valid_i),
    .pixel_value_i (pixel_value_i),
    .in_stall_o    (in_stall_o),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .tile_sum_o    (f_sum),
    .tile_row_o    (f_row),
    .tile_col_o    (f_col),
    .tile_last_o   (f_last)
  );

  assign q_wdata = {f_sum, f_row, f_col, f_last};

  thef_fifo #(
    .Width (EntryW),
    .Depth (thef_pkg::FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  thef_back #(
    .FEATURE_BITS (FEATURE_BITS),
    .RowW         (RowW),
    .ColW         (ColW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_i           (win_sat),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .q_sum_i         (q_rdata[EntryW-1 -: SumW]),
    .q_row_i         (q_rdata[RowW+ColW:ColW+1]),
    .q_col_i         (q_rdata[ColW:1]),
    .q_last_i        (q_rdata[0]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .feature_o       (feature_o),
    .tile_row_o      (tile_row_o),
    .tile_col_o      (tile_col_o),
    .last_of_image_o (last_of_image_o)
  );

endmodule

`default_nettype wire
